FILE: hdl/bilat_pkg.sv
package bilat_pkg;

   localparam int MAX_RADIUS_DEF = 8;
   localparam int MAX_ROW_DEF    = 8192;
   localparam int SAMPLE_W       = 17;
   localparam int REQ_DATA_W     = 56;  // 55 bits of fields, padded to bytes
   localparam int RSP_DATA_W     = 40;  // 34 bits of fields, padded to bytes
   localparam int CSR_INDEX_W    = 8;

   localparam logic [32:0] LOG2E_Q16 = 33'd94548;
   localparam logic [11:0] EXP_CAP   = 12'd4095;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_COEF  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_CHANNEL = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS      = 8'd3;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_TABLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRONT,
      ST_CENTER,
      ST_TAP,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_CEMIT,
      ST_FLUSH
   } state_type;

   // round(2^(16 - i/16)), i = 0..16
   function automatic logic [16:0] pow2_neg(input logic [4:0] i);
      logic [16:0] v;
      case (i)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/bilateral_row_filter_core.sv
// Timing: a head-of-row item goes via the front state to the output register; a filtered
//   pixel passes the center state, tap work for 2R+1 taps on the shared multiplier, serial
//   division per channel (cut short on a zero weight sum or saturation) and the emit state.
// Throughput: one item at a time; a table write leaves the block idle, trailing results
//   leave from the flush state, and in bypass the center sample skips the tap work.
// Reset (synchronous, active high) clears windows, spatial table, row position and
//   restores radius 1, range_coef 0, two_channel 0, bypass 1; no clearing pass.
module bilateral_row_filter_core #(
   parameter int MAX_RADIUS = bilat_pkg::MAX_RADIUS_DEF,
   parameter int MAX_ROW    = bilat_pkg::MAX_ROW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request item
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_a[16:0], sample_b[33:17], kernel_index[38:34], kernel_value[54:39], pad
   input  logic [bilat_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,   // cmd
   input  logic                                req_tlast,   // last_in_row
   // result item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bilat_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // out_a[16:0], out_b[33:17], pad
   output logic                                rsp_tlast,   // last_out
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bilat_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                         csr_data
);

   localparam int WD   = 2 * MAX_RADIUS + 1;     // window depth
   localparam int WIW  = $clog2(WD);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int PW   = $clog2(MAX_ROW);
   localparam int DENW = 17 + $clog2(WD);
   localparam int NUMW = 34 + $clog2(WD);
   localparam int REMW = NUMW + 2;
   localparam int SW   = bilat_pkg::SAMPLE_W;

   // ---------------- registers ----------------
   bilat_pkg::state_type state_ff, state_in;

   logic [3:0]           radius_ff, radius_in;
   logic [31:0]          coef_ff, coef_in;
   logic                 two_ff, two_in;
   logic                 bypass_ff, bypass_in;

   logic signed [SW-1:0] win_a_ff [WD];
   logic signed [SW-1:0] win_a_in [WD];
   logic signed [SW-1:0] win_b_ff [WD];
   logic signed [SW-1:0] win_b_in [WD];
   logic [15:0]          tab_ff [WD];
   logic [15:0]          tab_in [WD];

   logic [PW-1:0]        pos_ff, pos_in;
   logic [RW-1:0]        rrow_ff, rrow_in;
   logic                 last_ff, last_in;
   logic                 flush_ff, flush_in;
   logic [WIW-1:0]       fj_ff, fj_in;

   // tap datapath
   logic [3:0]           step_ff, step_in;
   logic [WIW-1:0]       j_ff, j_in;
   logic [WIW-1:0]       k_ff, k_in;
   logic signed [SW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic signed [SW-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [16:0]          da_ff, da_in, db_ff, db_in;
   logic [15:0]          sp_ff, sp_in;
   logic [35:0]          d_ff, d_in;
   logic [39:0]          rt_ff, rt_in;
   logic [11:0]          e8_ff, e8_in;
   logic [4:0]           n_ff, n_in;
   logic [16:0]          hi_ff, hi_in;
   logic [11:0]          dlt_ff, dlt_in;
   logic [11:0]          fr_ff, fr_in;
   logic [16:0]          w_ff, w_in;
   logic [DENW-1:0]      den_ff, den_in;
   logic signed [NUMW-1:0] num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic signed [65:0]   prod_ff;

   // divider
   logic                 ch_ff, ch_in;
   logic                 neg_ff, neg_in;
   logic [REMW-1:0]      rem_ff, rem_in;
   logic [REMW-1:0]      dsh_ff, dsh_in;
   logic [17:0]          q_ff, q_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic signed [SW-1:0] res_a_ff, res_a_in, res_b_ff, res_b_in;

   // output stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic                 out_last_ff, out_last_in;

   // ---------------- shared multiplier ----------------
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   prod;
   assign prod = mul_a * mul_b;

   // single window read port
   logic [WIW-1:0]       rd_idx;
   logic signed [SW-1:0] rd_a, rd_b;
   assign rd_a = win_a_ff[rd_idx];
   assign rd_b = win_b_ff[rd_idx];

   // request unpacking
   logic signed [SW-1:0] req_sample_a, req_sample_b;
   logic [4:0]           req_kernel_index;
   logic [15:0]          req_kernel_value;
   assign req_sample_a     = req_tdata[16:0];
   assign req_sample_b     = req_tdata[33:17];
   assign req_kernel_index = req_tdata[38:34];
   assign req_kernel_value = req_tdata[54:39];

   assign req_tready = (state_ff == bilat_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(bilat_pkg::RSP_DATA_W - 2*SW){1'b0}}, out_b_ff, out_a_ff};

   // ---------------- next state ----------------
   logic                 out_free;
   logic [RW-1:0]        r_use;
   logic signed [17:0]   dfa, dfb;
   logic [44:0]          esum;
   logic [3:0]           fi;
   logic [16:0]          lo_v;
   logic [23:0]          corr;
   logic [16:0]          m_v;
   logic signed [NUMW-1:0] num_sel;
   logic [NUMW-1:0]      mag;
   logic [REMW-1:0]      rem_init, lim;
   logic signed [18:0]   sq;
   logic signed [SW-1:0] sres;
   int                   pos_i, r_i;

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      coef_in      = coef_ff;
      two_in       = two_ff;
      bypass_in    = bypass_ff;
      win_a_in     = win_a_ff;
      win_b_in     = win_b_ff;
      tab_in       = tab_ff;
      pos_in       = pos_ff;
      rrow_in      = rrow_ff;
      last_in      = last_ff;
      flush_in     = flush_ff;
      fj_in        = fj_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      sp_in        = sp_ff;
      d_in         = d_ff;
      rt_in        = rt_ff;
      e8_in        = e8_ff;
      n_in         = n_ff;
      hi_in        = hi_ff;
      dlt_in       = dlt_ff;
      fr_in        = fr_ff;
      w_in         = w_ff;
      den_in       = den_ff;
      num_a_in     = num_a_ff;
      num_b_in     = num_b_ff;
      ch_in        = ch_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_last_in  = out_last_ff;
      mul_a        = '0;
      mul_b        = '0;
      rd_idx       = '0;
      r_use        = rrow_ff;
      dfa          = '0;
      dfb          = '0;
      esum         = '0;
      fi           = '0;
      lo_v         = '0;
      corr         = '0;
      m_v          = '0;
      num_sel      = '0;
      mag          = '0;
      rem_init     = '0;
      lim          = '0;
      sq           = '0;
      sres         = '0;
      pos_i        = 0;
      r_i          = 0;

      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // register writes
      if (csr_valid) begin
         if (csr_index == bilat_pkg::CSR_RADIUS) radius_in = csr_data[3:0];
         else if (csr_index == bilat_pkg::CSR_RANGE_COEF) coef_in = csr_data;
         else if (csr_index == bilat_pkg::CSR_TWO_CHANNEL) two_in = csr_data[0];
         else if (csr_index == bilat_pkg::CSR_BYPASS) bypass_in = csr_data[0];
      end

      case (state_ff)
         bilat_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == bilat_pkg::CMD_TABLE) begin
                  for (int e = 0; e < WD; e++) begin
                     if (int'(req_kernel_index) == e) tab_in[e] = req_kernel_value;
                  end
               end else begin
                  for (int e = 1; e < WD; e++) begin
                     win_a_in[e] = win_a_ff[e-1];
                     win_b_in[e] = win_b_ff[e-1];
                  end
                  win_a_in[0] = req_sample_a;
                  win_b_in[0] = req_sample_b;
                  // radius is latched at the start of each row
                  if (pos_ff == '0) begin
                     r_use = (int'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);
                  end
                  rrow_in   = r_use;
                  pos_i     = int'(pos_ff);
                  r_i       = int'(r_use);
                  last_in   = req_tlast;
                  flush_in  = req_tlast && (pos_i >= r_i) && !((pos_i >= 2 * r_i) && (r_i == 0));
                  fj_in     = (pos_i >= 2 * r_i) ? WIW'(r_i - 1) : WIW'(pos_i - r_i);
                  if (req_tlast) pos_in = '0;
                  else if (int'(pos_ff) < MAX_ROW - 1) pos_in = pos_ff + PW'(1);
                  if (pos_i < r_i) state_in = bilat_pkg::ST_FRONT;
                  else if (pos_i >= 2 * r_i) state_in = bilat_pkg::ST_CENTER;
                  else if (req_tlast) state_in = bilat_pkg::ST_FLUSH;
               end
            end
         end

         // head of row: the new sample goes out as it is
         bilat_pkg::ST_FRONT: begin
            rd_idx = '0;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_a_in     = rd_a;
               out_b_in     = two_ff ? rd_b : '0;
               out_last_in  = last_ff;
               state_in     = bilat_pkg::ST_IDLE;
            end
         end

         bilat_pkg::ST_CENTER: begin
            rd_idx   = WIW'(rrow_ff);
            ca_in    = rd_a;
            cb_in    = rd_b;
            res_a_in = rd_a;
            res_b_in = rd_b;
            j_in     = WIW'({rrow_ff, 1'b0});
            k_in     = '0;
            step_in  = '0;
            den_in   = '0;
            num_a_in = '0;
            num_b_in = '0;
            state_in = bypass_ff ? bilat_pkg::ST_CEMIT : bilat_pkg::ST_TAP;
         end

         // one tap: 14 steps through the shared multiplier
         bilat_pkg::ST_TAP: begin
            rd_idx  = j_ff;
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  sa_in = rd_a;
                  sb_in = rd_b;
                  dfa   = 18'(rd_a) - 18'(ca_ff);
                  dfb   = 18'(rd_b) - 18'(cb_ff);
                  da_in = dfa[17] ? 17'(-dfa) : dfa[16:0];
                  db_in = dfb[17] ? 17'(-dfb) : dfb[16:0];
                  sp_in = tab_ff[k_ff];
               end
               4'd1: begin
                  mul_a = $signed({16'b0, da_ff});
                  mul_b = $signed({16'b0, da_ff});
               end
               4'd2: begin
                  mul_a = $signed({16'b0, db_ff});
                  mul_b = $signed({16'b0, db_ff});
                  d_in  = prod_ff[35:0];
               end
               4'd3: begin
                  if (two_ff) d_in = d_ff + prod_ff[35:0];
               end
               4'd4: begin
                  mul_a = $signed({1'b0, coef_ff});
                  mul_b = $signed({1'b0, d_ff[31:0]});
               end
               4'd5: begin
                  mul_a = $signed({1'b0, coef_ff});
                  mul_b = $signed({29'b0, d_ff[35:32]});
                  rt_in = prod_ff[63:24];
               end
               4'd6: begin
                  // coef*d / 2^24 plus spatial exponent, capped
                  esum  = {5'b0, rt_ff} + {1'b0, prod_ff[35:0], 8'b0} + {29'b0, sp_ff};
                  e8_in = (esum > 45'(bilat_pkg::EXP_CAP)) ? bilat_pkg::EXP_CAP : esum[11:0];
               end
               4'd7: begin
                  mul_a = $signed({21'b0, e8_ff});
                  mul_b = $signed(bilat_pkg::LOG2E_Q16);
               end
               4'd8: begin
                  n_in   = prod_ff[28:24];
                  fi     = prod_ff[23:20];
                  hi_in  = bilat_pkg::pow2_neg({1'b0, fi});
                  lo_v   = bilat_pkg::pow2_neg({1'b0, fi} + 5'd1);
                  dlt_in = 12'(hi_in - lo_v);
                  fr_in  = prod_ff[19:8];
               end
               4'd9: begin
                  mul_a = $signed({21'b0, dlt_ff});
                  mul_b = $signed({21'b0, fr_ff});
               end
               4'd10: begin
                  corr = prod_ff[23:0] + 24'd2048;
                  m_v  = hi_ff - {5'b0, corr[23:12]};
                  w_in = (n_ff >= 5'd17) ? '0 : (m_v >> n_ff);
               end
               4'd11: begin
                  mul_a  = $signed({16'b0, w_ff});
                  mul_b  = $signed({{16{sa_ff[SW-1]}}, sa_ff});
                  den_in = den_ff + DENW'(w_ff);
               end
               4'd12: begin
                  mul_a    = $signed({16'b0, w_ff});
                  mul_b    = $signed({{16{sb_ff[SW-1]}}, sb_ff});
                  num_a_in = num_a_ff + NUMW'(prod_ff);
               end
               4'd13: begin
                  num_b_in = num_b_ff + NUMW'(prod_ff);
                  step_in  = '0;
                  if (j_ff == '0) begin
                     ch_in    = 1'b0;
                     state_in = bilat_pkg::ST_DIV_INIT;
                  end else begin
                     j_in = j_ff - WIW'(1);
                     k_in = k_ff + WIW'(1);
                  end
               end
               default: step_in = '0;
            endcase
         end

         // q = (2|num| + den) / (2 den), forced to 65536 if it would reach 2^17
         bilat_pkg::ST_DIV_INIT: begin
            num_sel  = ch_ff ? num_b_ff : num_a_ff;
            neg_in   = num_sel[NUMW-1];
            mag      = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
            rem_init = {1'b0, mag, 1'b0} + REMW'(den_ff);
            lim      = REMW'({den_ff, 1'b0}) << 17;
            rem_in   = rem_init;
            dsh_in   = REMW'({den_ff, 1'b0}) << 16;
            cnt_in   = 5'd16;
            q_in     = '0;
            if (den_ff == '0) begin
               state_in = bilat_pkg::ST_DIV_DONE;
            end else if (rem_init >= lim) begin
               q_in     = 18'd65536;
               state_in = bilat_pkg::ST_DIV_DONE;
            end else begin
               state_in = bilat_pkg::ST_DIV_STEP;
            end
         end

         bilat_pkg::ST_DIV_STEP: begin
            if (rem_ff >= dsh_ff) begin
               rem_in       = rem_ff - dsh_ff;
               q_in[cnt_ff] = 1'b1;
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = bilat_pkg::ST_DIV_DONE;
         end

         bilat_pkg::ST_DIV_DONE: begin
            sq   = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
            sres = (sq > 19'sd65535) ? 17'sd65535 : sq[16:0];
            if (ch_ff) res_b_in = sres;
            else res_a_in = sres;
            if (!ch_ff && two_ff) begin
               ch_in    = 1'b1;
               state_in = bilat_pkg::ST_DIV_INIT;
            end else begin
               state_in = bilat_pkg::ST_CEMIT;
            end
         end

         bilat_pkg::ST_CEMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_a_in     = res_a_ff;
               out_b_in     = two_ff ? res_b_ff : '0;
               out_last_in  = last_ff && !flush_ff;
               state_in     = flush_ff ? bilat_pkg::ST_FLUSH : bilat_pkg::ST_IDLE;
            end
         end

         // row end: trailing pixels pass through, oldest first
         bilat_pkg::ST_FLUSH: begin
            rd_idx = fj_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_a_in     = rd_a;
               out_b_in     = two_ff ? rd_b : '0;
               out_last_in  = (fj_ff == '0);
               if (fj_ff == '0) state_in = bilat_pkg::ST_IDLE;
               else fj_in = fj_ff - WIW'(1);
            end
         end

         default: state_in = bilat_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control and state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bilat_pkg::ST_IDLE;
         radius_ff    <= 4'd1;
         coef_ff      <= '0;
         two_ff       <= 1'b0;
         bypass_ff    <= 1'b1;
         pos_ff       <= '0;
         rrow_ff      <= RW'(1);
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < WD; e++) begin
            win_a_ff[e] <= '0;
            win_b_ff[e] <= '0;
            tab_ff[e]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         coef_ff      <= coef_in;
         two_ff       <= two_in;
         bypass_ff    <= bypass_in;
         pos_ff       <= pos_in;
         rrow_ff      <= rrow_in;
         rsp_valid_ff <= rsp_valid_in;
         win_a_ff     <= win_a_in;
         win_b_ff     <= win_b_in;
         tab_ff       <= tab_in;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      flush_ff    <= flush_in;
      fj_ff       <= fj_in;
      step_ff     <= step_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      sp_ff       <= sp_in;
      d_ff        <= d_in;
      rt_ff       <= rt_in;
      e8_ff       <= e8_in;
      n_ff        <= n_in;
      hi_ff       <= hi_in;
      dlt_ff      <= dlt_in;
      fr_ff       <= fr_in;
      w_ff        <= w_in;
      den_ff      <= den_in;
      num_a_ff    <= num_a_in;
      num_b_ff    <= num_b_in;
      prod_ff     <= prod;
      ch_ff       <= ch_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: hdl/bilat_chk.sv
module bilat_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [bilat_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                               req_tuser,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bilat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [bilat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [31:0]                        csr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a table write leaves the block ready again in the next cycle
   a_table_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bilat_pkg::CMD_TABLE) |=> req_tready)
      else $error("table write held the block busy");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[bilat_pkg::RSP_DATA_W-1:2*bilat_pkg::SAMPLE_W] == '0))
      else $error("result padding not zero");

endmodule

bind bilateral_row_filter_core bilat_chk u_bilat_chk (.*);

FILE: tb/sv/bilateral_row_filter_core_tb.sv
`timescale 1ns / 1ps

module bilateral_row_filter_core_tb;

   localparam int WIN        = 2 * bilat_pkg::MAX_RADIUS_DEF + 1;
   localparam int ROW_LIMIT  = 64;     // short row limit so saturation is reached quickly
   localparam int IDLE_PCT   = 17;
   localparam int QUIET_WAIT = 400;    // longer than the work of one filtered pixel at the largest radius
   localparam int STALL_MAX  = 20000;  // cycles with no handshake at all

   typedef struct {
      logic              cmd;
      logic signed [16:0] a;
      logic signed [16:0] b;
      logic              last;
      logic [4:0]        kidx;
      logic [15:0]       kval;
   } req_item_type;

   typedef struct {
      logic [16:0] a;
      logic [16:0] b;
      logic        last;
   } pixel_type;

   // 2^(-i/16), rounded, Q1.16
   localparam int unsigned EXP2_FRAC [17] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
      44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // sample_a, sample_b, kernel_index, kernel_value, pad
   logic [bilat_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                             req_tuser  = 1'b0;  // cmd
   logic                             req_tlast  = 1'b0;  // last_in_row
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bilat_pkg::RSP_DATA_W-1:0] rsp_tdata;  // out_a, out_b, pad
   logic                             rsp_tlast;  // last_out
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [bilat_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                      csr_data   = '0;

   bilateral_row_filter_core #(.MAX_ROW(ROW_LIMIT)) dut (.*);

   always #5 clock = ~clock;

   // ---- predictor state: own copy of windows, table, row tracking and registers
   longint      win_a [WIN];
   longint      win_b [WIN];
   int unsigned spat_exp [WIN];
   int unsigned row_pos, row_r;
   int unsigned reg_radius, reg_coef;
   bit          reg_two, reg_bypass;

   req_item_type req_backlog[$];   // items waiting for the driver
   pixel_type    due_pixels[$];    // predicted outputs, oldest first

   int errors, items_sent, pixels_seen, table_writes, csr_writes, filtered_cnt;
   bit quiet_run;   // no random idling on either side

   // ---- fixed-point filter arithmetic
   function automatic int unsigned tap_weight(longint unsigned e8);
      longint unsigned t;
      int unsigned n, f, i, r, hi, lo, m;
      if (e8 > 4095) e8 = 4095;
      t  = e8 * 94548;         // log2(e) in Q16
      n  = 32'(t >> 24);
      f  = 32'(t & 64'hFFFFFF);
      i  = f >> 20;
      r  = (f >> 8) & 12'hFFF;
      hi = EXP2_FRAC[i];
      lo = EXP2_FRAC[i+1];
      m  = hi - (((hi - lo) * r + 2048) >> 12);
      return (n >= 17) ? 0 : (m >> n);
   endfunction

   function automatic longint unsigned range_exp(longint unsigned d);
      longint unsigned c;
      c = reg_coef;
      return ((c * (d >> 32)) << 8) + ((c * (d & 64'hFFFFFFFF)) >> 24);
   endfunction

   function automatic longint unsigned sqd(longint x, longint y);
      longint v;
      v = x - y;
      if (v < 0) v = -v;
      return v * v;
   endfunction

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag, q;
      longint s;
      if (den == 0) return 0;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (q > 65536) q = 65536;
      s = (num < 0) ? -longint'(q) : longint'(q);
      if (s > 65535) s = 65535;
      return s;
   endfunction

   function automatic void push_pixel(longint a, longint b, bit two);
      pixel_type px;
      px.a = a[16:0];
      px.b = two ? b[16:0] : 17'd0;
      px.last = 1'b0;
      due_pixels.push_back(px);
   endfunction

   // advance the filter model by one accepted item
   function automatic void predict_item(req_item_type it);
      int unsigned pos, r, start, n0, j;
      bit two;
      longint oa, ob, ca, cb, na, nb;
      longint unsigned den, d, w;
      if (it.cmd == bilat_pkg::CMD_TABLE) begin
         if (it.kidx < WIN) spat_exp[it.kidx] = {16'd0, it.kval};
         return;
      end
      pos = row_pos;
      if (pos == 0)
         row_r = (reg_radius > bilat_pkg::MAX_RADIUS_DEF) ? bilat_pkg::MAX_RADIUS_DEF : reg_radius;
      r   = row_r;
      two = reg_two;
      for (int i = WIN - 1; i > 0; i--) begin
         win_a[i] = win_a[i-1];
         win_b[i] = win_b[i-1];
      end
      win_a[0] = it.a;
      win_b[0] = it.b;
      n0 = due_pixels.size();
      if (pos < r) push_pixel(win_a[0], win_b[0], two);
      if (pos >= 2 * r) begin
         oa = win_a[r];
         ob = win_b[r];
         if (!reg_bypass) begin
            ca = oa; cb = ob; na = 0; nb = 0; den = 0;
            for (int k = 0; k <= 2 * r; k++) begin
               j = 2 * r - k;
               d = sqd(win_a[j], ca);
               if (two) d += sqd(win_b[j], cb);
               w = tap_weight(range_exp(d) + spat_exp[k]);
               na += longint'(w) * win_a[j];
               nb += longint'(w) * win_b[j];
               den += w;
            end
            oa = round_div(na, den);
            ob = round_div(nb, den);
            filtered_cnt++;
         end
         push_pixel(oa, ob, two);
      end
      if (it.last) begin
         // tail of the row flushes out with the last sample
         start = (pos + 1 > r) ? pos + 1 - r : 0;
         if (start < r) start = r;
         for (int unsigned p = start; p <= pos; p++)
            push_pixel(win_a[pos-p], win_b[pos-p], two);
         if (due_pixels.size() > n0) due_pixels[due_pixels.size()-1].last = 1'b1;
         row_pos = 0;
      end else begin
         row_pos = (pos + 1 > ROW_LIMIT - 1) ? ROW_LIMIT - 1 : pos + 1;
      end
   endfunction

   // ---- driver: one item at a time from the backlog
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_item(req_backlog.pop_front());
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 &&
                (quiet_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= req_backlog[0].cmd;
               req_tlast  <= req_backlog[0].last;
               req_tdata  <= {1'b0, req_backlog[0].kval, req_backlog[0].kidx,
                              req_backlog[0].b, req_backlog[0].a};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---- monitor: compare each output item, random back-pressure, one long hold-off
   int  hold_cnt;
   bit  hold_done;
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            pixels_seen++;
            if (due_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected output a=%h b=%h last=%b", $time,
                        rsp_tdata[16:0], rsp_tdata[33:17], rsp_tlast);
            end else begin
               px = due_pixels.pop_front();
               if (rsp_tdata[16:0] !== px.a) begin
                  errors++;
                  $display("%0t: out_a expected %h actual %h", $time, px.a, rsp_tdata[16:0]);
               end
               if (rsp_tdata[33:17] !== px.b) begin
                  errors++;
                  $display("%0t: out_b expected %h actual %h", $time, px.b, rsp_tdata[33:17]);
               end
               if (rsp_tlast !== px.last) begin
                  errors++;
                  $display("%0t: last_out expected %b actual %b", $time, px.last, rsp_tlast);
               end
            end
         end
         // long hold-off once, while the sender keeps offering
         if (!hold_done && pixels_seen >= 60 && req_backlog.size() > 20) begin
            hold_done = 1'b1;
            hold_cnt  = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ---- watchdog
   int stall_cycles;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("%0t: timeout, %0d outputs still due", $time, due_pixels.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---- stimulus helpers
   task automatic write_reg(logic [bilat_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         bilat_pkg::CSR_RADIUS:      reg_radius = {28'd0, val[3:0]};
         bilat_pkg::CSR_RANGE_COEF:  reg_coef   = val;
         bilat_pkg::CSR_TWO_CHANNEL: reg_two    = val[0];
         bilat_pkg::CSR_BYPASS:      reg_bypass = val[0];
         default: ;
      endcase
   endtask

   task automatic set_all(int unsigned r, int unsigned c, bit two, bit byp);
      write_reg(bilat_pkg::CSR_RADIUS, r);
      write_reg(bilat_pkg::CSR_RANGE_COEF, c);
      write_reg(bilat_pkg::CSR_TWO_CHANNEL, {31'd0, two});
      write_reg(bilat_pkg::CSR_BYPASS, {31'd0, byp});
   endtask

   // everything drained, then room for a pixel still in the pipe
   task automatic wait_quiet();
      do @(posedge clock);
      while (req_backlog.size() > 0 || req_tvalid || due_pixels.size() > 0);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic add_table(int unsigned idx, int unsigned val);
      req_item_type it;
      it = '{cmd: bilat_pkg::CMD_TABLE, a: 17'($urandom), b: 17'($urandom),
             last: 1'($urandom_range(0, 1)), kidx: 5'(idx), kval: 16'(val)};
      req_backlog.push_back(it);
      table_writes++;
   endtask

   function automatic logic [16:0] pick_sample(int base);
      int v;
      case ($urandom_range(0, 9))
         0: v = -65536;
         1: v = 65535;
         2: v = $urandom;
         default: begin
            v = base + $urandom_range(0, 300) - 150;
            if (v > 65535) v = 65535;
            if (v < -65536) v = -65536;
         end
      endcase
      return v[16:0];
   endfunction

   // a run of pixels; close marks the last one as the end of the row
   task automatic add_pixels(int n, bit close);
      req_item_type it;
      int base;
      base = $urandom_range(0, 131071) - 65536;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_table($urandom_range(0, 31), $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1500));
         it = '{cmd: bilat_pkg::CMD_PIXEL, a: pick_sample(base), b: pick_sample(base),
                last: close && (i == n - 1), kidx: 5'($urandom), kval: 16'($urandom)};
         req_backlog.push_back(it);
      end
   endtask

   task automatic random_rows(int budget);
      int n;
      while (budget > 0) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 30);
         add_pixels(n, 1'b1);
         budget -= n;
      end
   endtask

   initial begin
      foreach (win_a[i]) begin
         win_a[i] = 0; win_b[i] = 0; spat_exp[i] = 0;
      end
      row_pos = 0; row_r = 1;
      reg_radius = 1; reg_coef = 0; reg_two = 0; reg_bypass = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: table extremes and ignored indexes, defaults (bypass, radius 1)
      add_table(0, 0);
      add_table(16, 16'hFFFF);
      add_table(17, 16'h1234);    // beyond the window, dropped
      add_table(31, 16'hFFFF);
      add_pixels(1, 1'b1);        // single-pixel row
      add_pixels(4, 1'b1);
      wait_quiet();

      // directed: filtering on, spatial-only weights, sample extremes
      set_all(1, 0, 0, 0);
      for (int k = 0; k < WIN; k++) add_table(k, 16'h0040 * k);
      add_pixels(8, 1'b1);
      wait_quiet();
      set_all(2, 32'hFFFF_FFFF, 1, 0);    // huge range term: most off-center weights underflow
      add_pixels(7, 1'b1);
      add_pixels(3, 1'b1);                // short row, all pass-through
      wait_quiet();

      // radius change in the middle of a row applies to the next row
      set_all(1, 32'h0100_0000, 1, 0);
      add_pixels(6, 1'b0);
      wait_quiet();
      write_reg(bilat_pkg::CSR_RADIUS, 3);
      add_pixels(6, 1'b1);
      add_pixels(10, 1'b1);
      wait_quiet();

      // random rows over several settings
      set_all(1, 32'h0100_0000, 0, 0);  random_rows(25); wait_quiet();
      set_all(8, 32'h0010_0000, 1, 0);  random_rows(25); wait_quiet();
      set_all(0, 32'h0040_0000, 1, 0);  random_rows(20); wait_quiet();
      quiet_run = 1'b1;
      set_all(15, 32'h0001_0000, 0, 0); random_rows(25); wait_quiet();  // clamps to 8
      quiet_run = 1'b0;
      set_all(3, $urandom, 1, 0);       random_rows(25); wait_quiet();
      set_all(2, $urandom, 0, 1);       random_rows(20); wait_quiet();
      set_all($urandom_range(0, 15), $urandom_range(0, 32'h0200_0000), 1, 0);
      random_rows(40);
      wait_quiet();
      write_reg(8'd9, 32'hFFFF_FFFF);     // unmapped register, no effect
      random_rows(10);
      wait_quiet();

      // over-long row in bypass: row position saturates
      set_all(1, 0, 1, 1);
      add_pixels(ROW_LIMIT + 10, 1'b1);
      wait_quiet();

      $display("covered %0d items (%0d table writes), %0d outputs, %0d filtered pixels,",
               items_sent, table_writes, pixels_seen, filtered_cnt);
      $display("%0d register writes across radius 0..15, bypass and both channel modes",
               csr_writes);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
